FILE: hdl/bads_pkg.sv
`default_nettype none

package bads_pkg;

   localparam int PixW         = 8;
   localparam int SumW         = 30;
   localparam int RegW         = 12;
   localparam int CoordW       = 11;
   localparam int DataW        = 32;
   localparam int AddrW        = 4;
   localparam int NumLanes     = 3;
   localparam int MaxWidthDef  = 2048;
   localparam int MaxHeightDef = 2048;

   typedef enum logic [1:0] {
      RegImageWidth,
      RegImageHeight,
      RegBlockWidth,
      RegBlockHeight
   } reg_idx_type;

endpackage

`default_nettype wire

FILE: hdl/bads_if.sv
`default_nettype none

interface bads_pix_if;
   import bads_pkg::*;
   logic            valid;
   logic            ready;
   logic [PixW-1:0] red;
   logic [PixW-1:0] green;
   logic [PixW-1:0] blue;

   modport source(output valid, red, green, blue, input ready);
   modport sink(input valid, red, green, blue, output ready);
endinterface

interface bads_blk_if;
   import bads_pkg::*;
   logic              valid;
   logic              ready;
   logic [PixW-1:0]   avg_red;
   logic [PixW-1:0]   avg_green;
   logic [PixW-1:0]   avg_blue;
   logic [CoordW-1:0] block_col;
   logic [CoordW-1:0] block_row_index;
   logic              row_end;

   modport source(output valid, avg_red, avg_green, avg_blue, block_col, block_row_index,
                  row_end, input ready);
   modport sink(input valid, avg_red, avg_green, avg_blue, block_col, block_row_index,
                row_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/block_average_downscale_core.sv
// Channel  Dir  Handshake              Payload
// req      in   valid/ready            red, green, blue (one pixel, raster order)
// rsp      out  valid/ready            avg_red/green/blue, block_col, block_row_index, row_end
// csr      in   APB psel/penable/pwrite image_width, image_height, block_width, block_height
//
// A pixel is accepted, then takes four steps through the one shared multiplier
// (block bounds, last-block test, row bounds, block area) while the sum RAM is read and
// written back. A pixel that closes a block adds bit-serial division (three channel
// lanes in step) and a step to load the output register.
// Reset is synchronous; the sum RAM is not cleared, a block's first pixel overwrites it.
// A result waiting in the output register does not stop intake; only a second finished
// block stalls until the first result is taken.
`default_nettype none

module block_average_downscale_core #(
   parameter int MAX_WIDTH  = bads_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = bads_pkg::MaxHeightDef
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bads_pix_if.sink                           req,
   bads_blk_if.source                         rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bads_pkg::AddrW-1:0]    paddr,
   input  wire logic [bads_pkg::DataW-1:0]    pwdata,
   output logic      [bads_pkg::DataW-1:0]    prdata,
   output logic                               pready
);
   import bads_pkg::*;

   localparam int XW     = $clog2(MAX_WIDTH + 1);
   localparam int YW     = $clog2(MAX_HEIGHT + 1);
   localparam int MW     = ((XW > YW) ? XW : YW) + 1;
   localparam int PW     = 2 * MW;
   localparam int AW     = XW + YW;
   localparam int RamAW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int StepW  = $clog2(SumW);
   localparam int RamW   = NumLanes * SumW;

   typedef enum logic [2:0] {
      S_IDLE, S_MCOL, S_MLAST, S_MROW, S_MAREA, S_DIV, S_DONE
   } state_type;

   // control
   state_type        state_ff, state_in;
   logic [RegW-1:0]  img_w_ff, img_w_in, img_h_ff, img_h_in;
   logic [RegW-1:0]  blk_w_ff, blk_w_in, blk_h_ff, blk_h_in;
   logic [XW-1:0]    pcol_ff, pcol_in, cib_ff, cib_in, cbc_ff, cbc_in;
   logic [YW-1:0]    prow_ff, prow_in, rib_ff, rib_in, cbr_ff, cbr_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [PixW-1:0]   pix_ff [NumLanes];
   logic [PixW-1:0]   pix_in [NumLanes];
   logic              in_col_ff, in_col_in, last_ff, last_in, in_row_ff, in_row_in;
   logic [AW-1:0]     area_ff, area_in;
   logic [AW-1:0]     rem_ff [NumLanes];
   logic [AW-1:0]     rem_in [NumLanes];
   logic [SumW-1:0]   quo_ff [NumLanes];
   logic [SumW-1:0]   quo_in [NumLanes];
   logic [CoordW-1:0] bcol_ff, bcol_in, brow_ff, brow_in;
   logic              bend_ff, bend_in;
   logic [CoordW-1:0] ocol_ff, ocol_in, orow_ff, orow_in;
   logic              oend_ff, oend_in;
   logic [PixW-1:0]   oavg_ff [NumLanes];
   logic [PixW-1:0]   oavg_in [NumLanes];

   // datapath
   logic [XW-1:0]   iw, bw;
   logic [YW-1:0]   ih, bh;
   logic [MW-1:0]   mul_a, mul_b;
   logic [PW-1:0]   prod;
   logic            cfg_wr;
   logic [RegW-1:0] cfg_rd;
   logic            ram_wr_en, ram_rd_en;
   logic [RamW-1:0] ram_wr_data, ram_rd_data;
   logic [SumW-1:0] old_sum [NumLanes];
   logic [SumW-1:0] new_sum [NumLanes];
   logic [AW:0]     div_shift [NumLanes];
   logic            div_ge [NumLanes];
   logic            blk_start, last_col, last_row, active;

   // zero acts as one, oversize clamps to the maximum
   function automatic logic [XW-1:0] eff_w(input logic [RegW-1:0] v);
      if (v == '0) return XW'(1);
      if (32'(v) > 32'(MAX_WIDTH)) return XW'(MAX_WIDTH);
      return XW'(v);
   endfunction

   function automatic logic [YW-1:0] eff_h(input logic [RegW-1:0] v);
      if (v == '0) return YW'(1);
      if (32'(v) > 32'(MAX_HEIGHT)) return YW'(MAX_HEIGHT);
      return YW'(v);
   endfunction

   assign iw = eff_w(img_w_ff);
   assign bw = eff_w(blk_w_ff);
   assign ih = eff_h(img_h_ff);
   assign bh = eff_h(blk_h_ff);

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      case (reg_idx_type'(paddr[AddrW-1:2]))
         RegImageWidth:  cfg_rd = img_w_ff;
         RegImageHeight: cfg_rd = img_h_ff;
         RegBlockWidth:  cfg_rd = blk_w_ff;
         RegBlockHeight: cfg_rd = blk_h_ff;
         default:        cfg_rd = '0;
      endcase
   end

   assign prdata = DataW'(cfg_rd);

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MCOL: begin
            mul_a = MW'(cbc_ff) + MW'(1);
            mul_b = MW'(bw);
         end
         S_MLAST: begin
            mul_a = MW'(cbc_ff) + MW'(2);
            mul_b = MW'(bw);
         end
         S_MROW: begin
            mul_a = MW'(cbr_ff) + MW'(1);
            mul_b = MW'(bh);
         end
         default: begin
            mul_a = MW'(bw);
            mul_b = MW'(bh);
         end
      endcase
   end

   assign prod = PW'(mul_a) * PW'(mul_b);

   // sum store
   assign ram_rd_en = (state_ff == S_MCOL);
   assign blk_start = (cib_ff == '0) && (rib_ff == '0);
   assign last_col  = ((XW + 1)'(cib_ff) + (XW + 1)'(1)) >= (XW + 1)'(bw);
   assign last_row  = ((YW + 1)'(rib_ff) + (YW + 1)'(1)) >= (YW + 1)'(bh);
   assign active    = in_col_ff && in_row_ff;
   assign ram_wr_en = (state_ff == S_MAREA) && active;

   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         old_sum[i] = ram_rd_data[i*SumW +: SumW];
         new_sum[i] = blk_start ? SumW'(pix_ff[i]) : old_sum[i] + SumW'(pix_ff[i]);
         ram_wr_data[i*SumW +: SumW] = new_sum[i];
         div_shift[i] = {rem_ff[i], quo_ff[i][SumW-1]};
         div_ge[i]    = div_shift[i] >= {1'b0, area_ff};
      end
   end

   bads_ram #(
      .WIDTH(RamW),
      .DEPTH(MAX_WIDTH)
   ) u_sum_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(RamAW'(cbc_ff)),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(RamAW'(cbc_ff)),
      .rd_data(ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      img_w_in     = img_w_ff;
      img_h_in     = img_h_ff;
      blk_w_in     = blk_w_ff;
      blk_h_in     = blk_h_ff;
      pcol_in      = pcol_ff;
      cib_in       = cib_ff;
      cbc_in       = cbc_ff;
      prow_in      = prow_ff;
      rib_in       = rib_ff;
      cbr_in       = cbr_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pix_in       = pix_ff;
      in_col_in    = in_col_ff;
      last_in      = last_ff;
      in_row_in    = in_row_ff;
      area_in      = area_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bcol_in      = bcol_ff;
      brow_in      = brow_ff;
      bend_in      = bend_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      oend_in      = oend_ff;
      oavg_in      = oavg_ff;

      if (cfg_wr) begin
         case (reg_idx_type'(paddr[AddrW-1:2]))
            RegImageWidth:  img_w_in = pwdata[RegW-1:0];
            RegImageHeight: img_h_in = pwdata[RegW-1:0];
            RegBlockWidth:  blk_w_in = pwdata[RegW-1:0];
            RegBlockHeight: blk_h_in = pwdata[RegW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               pix_in[0] = req.red;
               pix_in[1] = req.green;
               pix_in[2] = req.blue;
               state_in  = S_MCOL;
            end
         end
         S_MCOL: begin
            in_col_in = (prod <= PW'(iw)) && (32'(cbc_ff) < 32'(MAX_WIDTH));
            state_in  = S_MLAST;
         end
         S_MLAST: begin
            last_in  = prod > PW'(iw);
            state_in = S_MROW;
         end
         S_MROW: begin
            in_row_in = prod <= PW'(ih);
            state_in  = S_MAREA;
         end
         S_MAREA: begin
            area_in = AW'(prod);
            // block coordinates wait here; the output register may still hold a result
            bcol_in = CoordW'(cbc_ff);
            brow_in = CoordW'(cbr_ff);
            bend_in = last_ff;
            for (int i = 0; i < NumLanes; i++) begin
               rem_in[i] = '0;
               quo_in[i] = new_sum[i];
            end
            step_in  = '0;
            state_in = (active && last_col && last_row) ? S_DIV : S_IDLE;

            // advance raster position
            if (last_col) begin
               cib_in = '0;
               cbc_in = cbc_ff + XW'(1);
            end else begin
               cib_in = cib_ff + XW'(1);
            end
            if (((XW + 1)'(pcol_ff) + (XW + 1)'(1)) >= (XW + 1)'(iw)) begin
               pcol_in = '0;
               cib_in  = '0;
               cbc_in  = '0;
               if (last_row) begin
                  rib_in = '0;
                  cbr_in = cbr_ff + YW'(1);
               end else begin
                  rib_in = rib_ff + YW'(1);
               end
               if (((YW + 1)'(prow_ff) + (YW + 1)'(1)) >= (YW + 1)'(ih)) begin
                  prow_in = '0;
                  rib_in  = '0;
                  cbr_in  = '0;
               end else begin
                  prow_in = prow_ff + YW'(1);
               end
            end else begin
               pcol_in = pcol_ff + XW'(1);
            end
         end
         S_DIV: begin
            for (int i = 0; i < NumLanes; i++) begin
               rem_in[i] = div_ge[i] ? AW'(div_shift[i] - {1'b0, area_ff}) : AW'(div_shift[i]);
               quo_in[i] = {quo_ff[i][SumW-2:0], div_ge[i]};
            end
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(SumW - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               for (int i = 0; i < NumLanes; i++) begin
                  oavg_in[i] = quo_ff[i][PixW-1:0];
               end
               ocol_in      = bcol_ff;
               orow_in      = brow_ff;
               oend_in      = bend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         img_w_ff     <= RegW'(1);
         img_h_ff     <= RegW'(1);
         blk_w_ff     <= RegW'(1);
         blk_h_ff     <= RegW'(1);
         pcol_ff      <= '0;
         cib_ff       <= '0;
         cbc_ff       <= '0;
         prow_ff      <= '0;
         rib_ff       <= '0;
         cbr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         img_w_ff     <= img_w_in;
         img_h_ff     <= img_h_in;
         blk_w_ff     <= blk_w_in;
         blk_h_ff     <= blk_h_in;
         pcol_ff      <= pcol_in;
         cib_ff       <= cib_in;
         cbc_ff       <= cbc_in;
         prow_ff      <= prow_in;
         rib_ff       <= rib_in;
         cbr_ff       <= cbr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff    <= pix_in;
      in_col_ff <= in_col_in;
      last_ff   <= last_in;
      in_row_ff <= in_row_in;
      area_ff   <= area_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      bcol_ff   <= bcol_in;
      brow_ff   <= brow_in;
      bend_ff   <= bend_in;
      ocol_ff   <= ocol_in;
      orow_ff   <= orow_in;
      oend_ff   <= oend_in;
      oavg_ff   <= oavg_in;
   end

   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.avg_red         = oavg_ff[0];
   assign rsp.avg_green       = oavg_ff[1];
   assign rsp.avg_blue        = oavg_ff[2];
   assign rsp.block_col       = ocol_ff;
   assign rsp.block_row_index = orow_ff;
   assign rsp.row_end         = oend_ff;

endmodule

`default_nettype wire

FILE: hdl/bads_ram.sv
`default_nettype none

module bads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bads_chk.sv
`default_nettype none

module bads_chk (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [bads_pkg::PixW-1:0]     avg_red,
   input wire logic [bads_pkg::PixW-1:0]     avg_green,
   input wire logic [bads_pkg::PixW-1:0]     avg_blue,
   input wire logic [bads_pkg::CoordW-1:0]   block_col,
   input wire logic [bads_pkg::CoordW-1:0]   block_row_index,
   input wire logic                          row_end,
   input wire logic                          psel,
   input wire logic                          penable,
   input wire logic                          pwrite,
   input wire logic [bads_pkg::AddrW-1:0]    paddr,
   input wire logic [bads_pkg::DataW-1:0]    pwdata,
   input wire logic [bads_pkg::DataW-1:0]    prdata
);
   import bads_pkg::*;

   // every item goes through four multiplier steps before the next is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input taken during item processing");

   // a result only appears out of the output-load step, never while idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a finishing item");

   // written register reads back on the next cycle at the same address
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite) ##1 (paddr == $past(paddr))
      |-> (prdata == DataW'($past(pwdata[RegW-1:0]))))
      else $error("register readback mismatch");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(avg_red) && $stable(avg_green)
         && $stable(avg_blue) && $stable(block_col) && $stable(block_row_index)
         && $stable(row_end)))
      else $error("result payload changed while stalled");

endmodule

bind block_average_downscale_core bads_chk u_bads_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .avg_red        (rsp.avg_red),
   .avg_green      (rsp.avg_green),
   .avg_blue       (rsp.avg_blue),
   .block_col      (rsp.block_col),
   .block_row_index(rsp.block_row_index),
   .row_end        (rsp.row_end),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr),
   .pwdata         (pwdata),
   .prdata         (prdata)
);

`default_nettype wire
